// ===== rtl/core/hpac_pkg.sv =====
// Package with the shared configuration type, register indexes and constants of the hover controller.
package hpac_pkg;

	localparam int GAIN_SHIFT = 20;
	localparam logic signed [31:0] FEEDFORWARD = 32'sd2048;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ALTITUDE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALTITUDE_P_GAIN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ALTITUDE_I_GAIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_GAIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_MIN = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_MAX = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT = 3'd7;

	typedef struct packed {
		logic signed [15:0] target_altitude;
		logic [23:0] altitude_p_gain;
		logic [23:0] altitude_i_gain;
		logic [23:0] tilt_gain;
		logic [22:0] integral_limit;
		logic [12:0] throttle_min;
		logic [12:0] throttle_max;
		logic [12:0] tilt_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		target_altitude: -16'sd1229,
		altitude_p_gain: 24'd209715,
		altitude_i_gain: 24'd524,
		tilt_gain: 24'd104858,
		integral_limit: 23'd819200,
		throttle_min: 13'd1638,
		throttle_max: 13'd2744,
		tilt_limit: 13'd410
	};

endpackage

// ===== rtl/core/hpac_law.sv =====
// Control law of the hover controller: integrator update, PI throttle and P tilt with clamps.
module hpac_law (
	input  hpac_pkg::cfg_t      cfg,
	input  logic signed [15:0]  meas_x,
	input  logic signed [15:0]  meas_y,
	input  logic signed [15:0]  meas_z,
	input  logic signed [23:0]  error_sum,
	output logic signed [23:0]  error_sum_next,
	output logic [12:0]         throttle_cmd,
	output logic signed [13:0]  roll_ang,
	output logic signed [13:0]  pitch_ang
);

	logic signed [16:0] z_err;
	logic signed [24:0] sum_raw;
	logic signed [24:0] sum_lim;
	logic signed [24:0] sum_clamped;
	logic signed [17:0] neg_err;
	logic signed [24:0] neg_sum;
	logic signed [24:0] p_gain_s;
	logic signed [24:0] i_gain_s;
	logic signed [24:0] tilt_gain_s;
	logic signed [42:0] p_prod;
	logic signed [49:0] i_prod;
	logic signed [31:0] thr_sum;
	logic signed [31:0] thr_lo;
	logic signed [31:0] thr_hi;
	logic signed [31:0] thr_clamped;
	logic signed [16:0] neg_x;
	logic signed [41:0] roll_prod;
	logic signed [41:0] pitch_prod;
	logic signed [21:0] roll_term;
	logic signed [21:0] pitch_term;
	logic signed [21:0] tilt_lim;
	logic signed [21:0] roll_clamped;
	logic signed [21:0] pitch_clamped;

	assign p_gain_s = $signed({1'b0, cfg.altitude_p_gain});
	assign i_gain_s = $signed({1'b0, cfg.altitude_i_gain});
	assign tilt_gain_s = $signed({1'b0, cfg.tilt_gain});

	assign z_err = 17'(cfg.target_altitude) - 17'(meas_z);
	assign sum_raw = 25'(error_sum) + 25'(z_err);
	assign sum_lim = $signed({2'b00, cfg.integral_limit});

	always_comb begin
		sum_clamped = sum_raw;
		if (sum_clamped > sum_lim) begin
			sum_clamped = sum_lim;
		end
		if (sum_clamped < -sum_lim) begin
			sum_clamped = -sum_lim;
		end
	end

	assign error_sum_next = sum_clamped[23:0];

	assign neg_err = -18'(z_err);
	assign neg_sum = -sum_clamped;
	assign p_prod = p_gain_s * neg_err;
	assign i_prod = i_gain_s * neg_sum;

	// Taking the upper bits of a signed product is an arithmetic shift, rounding down.
	assign thr_sum = hpac_pkg::FEEDFORWARD
		+ 32'($signed(p_prod[42:hpac_pkg::GAIN_SHIFT]))
		+ 32'($signed(i_prod[49:hpac_pkg::GAIN_SHIFT]));
	assign thr_lo = $signed({19'b0, cfg.throttle_min});
	assign thr_hi = $signed({19'b0, cfg.throttle_max});

	always_comb begin
		thr_clamped = thr_sum;
		if (thr_clamped < thr_lo) begin
			thr_clamped = thr_lo;
		end
		if (thr_clamped > thr_hi) begin
			thr_clamped = thr_hi;
		end
	end

	assign throttle_cmd = thr_clamped[12:0];

	assign neg_x = -17'(meas_x);
	assign roll_prod = tilt_gain_s * neg_x;
	assign pitch_prod = tilt_gain_s * meas_y;
	assign roll_term = roll_prod[41:hpac_pkg::GAIN_SHIFT];
	assign pitch_term = pitch_prod[41:hpac_pkg::GAIN_SHIFT];
	assign tilt_lim = $signed({9'b0, cfg.tilt_limit});

	always_comb begin
		roll_clamped = roll_term;
		if (roll_clamped > tilt_lim) begin
			roll_clamped = tilt_lim;
		end
		if (roll_clamped < -tilt_lim) begin
			roll_clamped = -tilt_lim;
		end
		pitch_clamped = pitch_term;
		if (pitch_clamped > tilt_lim) begin
			pitch_clamped = tilt_lim;
		end
		if (pitch_clamped < -tilt_lim) begin
			pitch_clamped = -tilt_lim;
		end
	end

	assign roll_ang = roll_clamped[13:0];
	assign pitch_ang = pitch_clamped[13:0];

endmodule

// ===== rtl/core/hover_pi_altitude_p_tilt_controller.sv =====
// Top level of the hover controller: stream ports, configuration registers and integrator state.
// Each position sample (x, y, z) yields one command transaction (throttle, roll, pitch). A sample
// is registered on acceptance, the whole control law runs combinationally on the registered
// sample, and the result is captured in the output register, so one sample can be taken every
// cycle. The integrator update that feeds the integral multiply is registered on capture.
// Downstream stalls hold both stages; a new sample is still taken while a result waits if the
// input stage is empty. Configuration writes should only be issued while no samples are in
// flight.
module hover_pi_altitude_p_tilt_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [47:0]                         s_axis_tdata,  // meas_x, meas_y, meas_z
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [47:0]                         m_axis_tdata,  // throttle, roll, pitch, zero pad
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hpac_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [hpac_pkg::CFG_DATA_W-1:0]     cfg_data
);

	hpac_pkg::cfg_t cfg_q;
	logic signed [23:0] error_sum_q;
	logic signed [23:0] error_sum_next;

	logic valid_s1;
	logic signed [15:0] meas_x_s1;
	logic signed [15:0] meas_y_s1;
	logic signed [15:0] meas_z_s1;

	logic out_valid_q;
	logic [12:0] throttle_q;
	logic signed [13:0] roll_q;
	logic signed [13:0] pitch_q;

	logic [12:0] throttle_d;
	logic signed [13:0] roll_d;
	logic signed [13:0] pitch_d;

	logic advance;
	logic capture;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hpac_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hpac_pkg::REG_TARGET_ALTITUDE: cfg_q.target_altitude <= $signed(cfg_data[15:0]);
				hpac_pkg::REG_ALTITUDE_P_GAIN: cfg_q.altitude_p_gain <= cfg_data;
				hpac_pkg::REG_ALTITUDE_I_GAIN: cfg_q.altitude_i_gain <= cfg_data;
				hpac_pkg::REG_TILT_GAIN: cfg_q.tilt_gain <= cfg_data;
				hpac_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[22:0];
				hpac_pkg::REG_THROTTLE_MIN: cfg_q.throttle_min <= cfg_data[12:0];
				hpac_pkg::REG_THROTTLE_MAX: cfg_q.throttle_max <= cfg_data[12:0];
				hpac_pkg::REG_TILT_LIMIT: cfg_q.tilt_limit <= cfg_data[12:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign advance = !out_valid_q || m_axis_tready;
	assign capture = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			meas_x_s1 <= $signed(s_axis_tdata[15:0]);
			meas_y_s1 <= $signed(s_axis_tdata[31:16]);
			meas_z_s1 <= $signed(s_axis_tdata[47:32]);
		end
	end

	hpac_law u_law (
		.cfg            (cfg_q),
		.meas_x         (meas_x_s1),
		.meas_y         (meas_y_s1),
		.meas_z         (meas_z_s1),
		.error_sum      (error_sum_q),
		.error_sum_next (error_sum_next),
		.throttle_cmd   (throttle_d),
		.roll_ang       (roll_d),
		.pitch_ang      (pitch_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (capture) begin
				error_sum_q <= error_sum_next;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			throttle_q <= throttle_d;
			roll_q <= roll_d;
			pitch_q <= pitch_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'b0, pitch_q, roll_q, throttle_q};

	a_sum_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(capture) |-> (error_sum_q <= $signed({1'b0, $past(cfg_q.integral_limit)})
			&& error_sum_q >= -$signed({1'b0, $past(cfg_q.integral_limit)})))
		else $error("Error sum left its clamp window.");

	a_throttle_max: assert property (@(posedge clk) disable iff (!arst_n)
		$past(capture) |-> throttle_q <= $past(cfg_q.throttle_max))
		else $error("Throttle command above its upper bound.");

	a_roll_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(capture) |-> (roll_q <= $signed({1'b0, $past(cfg_q.tilt_limit)})
			&& roll_q >= -$signed({1'b0, $past(cfg_q.tilt_limit)})))
		else $error("Roll command outside the tilt limit.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("Input stalled while the output register is empty.");

endmodule

// ===== tb/tb_hover_pi_altitude_p_tilt_controller.sv =====
// Self-checking testbench for the hover controller with a built-in predictor of the control law.
module tb_hover_pi_altitude_p_tilt_controller;

	localparam int Q20_SHIFT = 20;
	localparam longint HOVER_THROTTLE = 2048;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 200;
	localparam logic [hpac_pkg::CFG_INDEX_W-1:0] REG_ORDER [8] = '{
		hpac_pkg::REG_TARGET_ALTITUDE, hpac_pkg::REG_ALTITUDE_P_GAIN,
		hpac_pkg::REG_ALTITUDE_I_GAIN, hpac_pkg::REG_TILT_GAIN,
		hpac_pkg::REG_INTEGRAL_LIMIT, hpac_pkg::REG_THROTTLE_MIN,
		hpac_pkg::REG_THROTTLE_MAX, hpac_pkg::REG_TILT_LIMIT
	};

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} position_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic signed [13:0] pitch;
		logic signed [13:0] roll;
		logic [12:0]        throttle;
	} command_t;

	typedef struct {
		position_t   pos;
		int unsigned gap_after;
	} sample_slot_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [47:0]                      s_axis_tdata = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [47:0]                      m_axis_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [hpac_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [hpac_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	hpac_pkg::cfg_t ctl_cfg = '{
		target_altitude: -16'sd1229,
		altitude_p_gain: 24'd209715,
		altitude_i_gain: 24'd524,
		tilt_gain: 24'd104858,
		integral_limit: 23'd819200,
		throttle_min: 13'd1638,
		throttle_max: 13'd2744,
		tilt_limit: 13'd410
	};
	longint alt_err_sum = 0;

	sample_slot_t sample_queue [$];
	command_t     expected_cmds [$];
	int           fail_count = 0;
	logic         sample_taken = 1'b0;
	bit           tx_gaps_on = 1'b0;
	bit           rx_stalls_on = 1'b0;
	int           hold_asked = 0;
	int           hold_seen = 0;
	int unsigned  tx_wait = 0;
	int unsigned  rx_wait = 0;

	hover_pi_altitude_p_tilt_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sym_limit(longint v, longint lim);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	function automatic command_t predict_commands(position_t p);
		longint z_err, thr, roll, pitch;
		command_t c;
		z_err = longint'($signed(ctl_cfg.target_altitude)) - longint'($signed(p.z));
		alt_err_sum = sym_limit(alt_err_sum + z_err, longint'(ctl_cfg.integral_limit));
		thr = HOVER_THROTTLE
			+ ((longint'(ctl_cfg.altitude_p_gain) * -z_err) >>> Q20_SHIFT)
			+ ((longint'(ctl_cfg.altitude_i_gain) * -alt_err_sum) >>> Q20_SHIFT);
		if (thr < longint'(ctl_cfg.throttle_min)) thr = longint'(ctl_cfg.throttle_min);
		if (thr > longint'(ctl_cfg.throttle_max)) thr = longint'(ctl_cfg.throttle_max);
		roll = sym_limit((longint'(ctl_cfg.tilt_gain) * -longint'($signed(p.x))) >>> Q20_SHIFT,
			longint'(ctl_cfg.tilt_limit));
		pitch = sym_limit((longint'(ctl_cfg.tilt_gain) * longint'($signed(p.y))) >>> Q20_SHIFT,
			longint'(ctl_cfg.tilt_limit));
		c = '0;
		c.throttle = thr[12:0];
		c.roll = roll[13:0];
		c.pitch = pitch[13:0];
		return c;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	always @(posedge clk) begin : check_proc
		command_t got, want;
		if (arst_n) begin
			sample_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got = command_t'(m_axis_tdata);
				if (expected_cmds.size() == 0) begin
					note_failure($sformatf("unexpected command transaction: thr=%0d roll=%0d pitch=%0d",
						got.throttle, got.roll, got.pitch));
				end else begin
					want = expected_cmds.pop_front();
					if (got.throttle !== want.throttle || got.roll !== want.roll
							|| got.pitch !== want.pitch) begin
						note_failure($sformatf(
							"command mismatch: expected thr=%0d roll=%0d pitch=%0d, got thr=%0d roll=%0d pitch=%0d",
							want.throttle, want.roll, want.pitch, got.throttle, got.roll, got.pitch));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_cmds.push_back(predict_commands(position_t'(s_axis_tdata)));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hpac_pkg::REG_TARGET_ALTITUDE: ctl_cfg.target_altitude = cfg_data[15:0];
					hpac_pkg::REG_ALTITUDE_P_GAIN: ctl_cfg.altitude_p_gain = cfg_data;
					hpac_pkg::REG_ALTITUDE_I_GAIN: ctl_cfg.altitude_i_gain = cfg_data;
					hpac_pkg::REG_TILT_GAIN: ctl_cfg.tilt_gain = cfg_data;
					hpac_pkg::REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = cfg_data[22:0];
					hpac_pkg::REG_THROTTLE_MIN: ctl_cfg.throttle_min = cfg_data[12:0];
					hpac_pkg::REG_THROTTLE_MAX: ctl_cfg.throttle_max = cfg_data[12:0];
					hpac_pkg::REG_TILT_LIMIT: ctl_cfg.tilt_limit = cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	always @(negedge clk) begin : feed_proc
		sample_slot_t slot;
		if (arst_n && (!s_axis_tvalid || sample_taken)) begin
			if (tx_wait > 0) begin
				tx_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				slot = sample_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= slot.pos;
				tx_wait = slot.gap_after;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drain_proc
		int r;
		if (arst_n) begin
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				rx_wait = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else if (!rx_stalls_on) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					rx_wait = (r >= 97) ? $urandom_range(15, 60) : $urandom_range(0, 2);
				end
			end
		end
	end

	function automatic void offer(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		sample_slot_t slot;
		int r;
		r = $urandom_range(0, 99);
		slot.pos = '{z: z, y: y, x: x};
		if (!tx_gaps_on || r < 70) slot.gap_after = 0;
		else if (r < 95) slot.gap_after = $urandom_range(1, 3);
		else slot.gap_after = $urandom_range(10, 40);
		sample_queue.push_back(slot);
	endfunction

	function automatic logic [15:0] rand_coord(logic [15:0] centre);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'hffff;
				3: return 16'h0000;
				default: return 16'h0001;
			endcase
		end
		if (r < 40) return 16'($urandom);
		return centre + 16'($urandom_range(0, 2047)) - 16'd1024;
	endfunction

	function automatic logic [hpac_pkg::CFG_DATA_W-1:0] reset_value(
		logic [hpac_pkg::CFG_INDEX_W-1:0] idx);
		case (idx)
			hpac_pkg::REG_TARGET_ALTITUDE: return 24'h00fb33;
			hpac_pkg::REG_ALTITUDE_P_GAIN: return 24'd209715;
			hpac_pkg::REG_ALTITUDE_I_GAIN: return 24'd524;
			hpac_pkg::REG_TILT_GAIN: return 24'd104858;
			hpac_pkg::REG_INTEGRAL_LIMIT: return 24'd819200;
			hpac_pkg::REG_THROTTLE_MIN: return 24'd1638;
			hpac_pkg::REG_THROTTLE_MAX: return 24'd2744;
			default: return 24'd410;
		endcase
	endfunction

	function automatic logic [hpac_pkg::CFG_DATA_W-1:0] pick_reg_value(
		logic [hpac_pkg::CFG_INDEX_W-1:0] idx);
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return reset_value(idx);
		if (r < 40) return '0;
		if (r < 50) return '1;
		if (r < 70) return 24'($urandom);
		return reset_value(idx) ^ (24'($urandom) >> $urandom_range(8, 23));
	endfunction

	task automatic write_reg(logic [hpac_pkg::CFG_INDEX_W-1:0] idx,
		logic [hpac_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sample_queue.size() != 0 || s_axis_tvalid
			|| expected_cmds.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin : timeout_proc
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus_proc
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(16'h0000, 16'h0000, 16'h0000);
		offer(16'h8000, 16'h8000, 16'h8000);
		offer(16'h7fff, 16'h7fff, 16'h7fff);
		offer(16'h7fff, 16'h8000, 16'h8000);
		offer(16'hffff, 16'h0001, 16'hfb33);
		offer(16'h0001, 16'hffff, 16'h7fff);
		wait_drained();

		// Inverted throttle window, zero limits and full-scale gains.
		write_reg(hpac_pkg::REG_TARGET_ALTITUDE, 24'h007fff);
		write_reg(hpac_pkg::REG_ALTITUDE_P_GAIN, 24'hffffff);
		write_reg(hpac_pkg::REG_ALTITUDE_I_GAIN, 24'hffffff);
		write_reg(hpac_pkg::REG_TILT_GAIN, 24'hffffff);
		write_reg(hpac_pkg::REG_INTEGRAL_LIMIT, 24'd0);
		write_reg(hpac_pkg::REG_THROTTLE_MIN, 24'd4096);
		write_reg(hpac_pkg::REG_THROTTLE_MAX, 24'd1000);
		write_reg(hpac_pkg::REG_TILT_LIMIT, 24'd0);
		@(posedge clk);
		offer(16'h8000, 16'h7fff, 16'h8000);
		offer(16'h7fff, 16'h8000, 16'h7fff);
		offer(16'h0000, 16'h0000, 16'h7fff);
		offer(16'h1234, 16'hedcb, 16'h0000);
		offer(16'hffff, 16'h0001, 16'hffff);
		wait_drained();

		// Bound registers and the integral gain written with all ones, so bounds lie above their nominal range.
		write_reg(hpac_pkg::REG_TARGET_ALTITUDE, 24'hff8000);
		write_reg(hpac_pkg::REG_ALTITUDE_P_GAIN, 24'd0);
		write_reg(hpac_pkg::REG_ALTITUDE_I_GAIN, 24'hffffff);
		write_reg(hpac_pkg::REG_INTEGRAL_LIMIT, 24'hffffff);
		write_reg(hpac_pkg::REG_THROTTLE_MIN, 24'hffffff);
		write_reg(hpac_pkg::REG_THROTTLE_MAX, 24'hffffff);
		write_reg(hpac_pkg::REG_TILT_LIMIT, 24'hffffff);
		@(posedge clk);
		offer(16'h8000, 16'h8000, 16'h7fff);
		offer(16'h7fff, 16'h7fff, 16'h7fff);
		offer(16'h0000, 16'h0000, 16'h8000);
		offer(16'h8000, 16'h7fff, 16'h0000);
		offer(16'h0100, 16'hff00, 16'h7fff);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			foreach (REG_ORDER[i])
				write_reg(REG_ORDER[i], pick_reg_value(REG_ORDER[i]));
			@(posedge clk);
			tx_gaps_on = (ph % 2) == 1;
			rx_stalls_on = (ph % 4) >= 2;
			for (int n = 0; n < PHASE_SAMPLES; n++)
				offer(rand_coord(16'h0000), rand_coord(16'h0000), rand_coord(ctl_cfg.target_altitude));
			wait_drained();
		end

		// Long receiver hold while samples keep arriving back to back.
		foreach (REG_ORDER[i])
			write_reg(REG_ORDER[i], reset_value(REG_ORDER[i]));
		@(posedge clk);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_asked++;
		for (int n = 0; n < 60; n++)
			offer(rand_coord(16'h0000), rand_coord(16'h0000), rand_coord(ctl_cfg.target_altitude));
		wait_drained();

		repeat (10) @(posedge clk);
		if (expected_cmds.size() != 0)
			note_failure($sformatf("%0d command transactions never arrived", expected_cmds.size()));
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
